[rtl/core/chunk_reassembly_receiver_macros.svh]
// ----------------------------------------------------------------------------
// chunk_reassembly_receiver assertion macros
// Shared concurrent assertion forms for the receiver's RTL modules.
// ----------------------------------------------------------------------------
`ifndef CHUNK_REASSEMBLY_RECEIVER_MACROS_SVH
`define CHUNK_REASSEMBLY_RECEIVER_MACROS_SVH

// same-cycle implication, disabled during reset
`define CRR_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("crr assertion failed");

// next-cycle implication, disabled during reset
`define CRR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("crr assertion failed");

`endif

[rtl/core/crr_pkg.sv]
// ----------------------------------------------------------------------------
// crr_pkg
// Sizes, result codes, control/status bundles and helpers of the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package crr_pkg;

  // store geometry
  localparam int CHUNKS          = 32;
  localparam int BYTES_PER_CHUNK = 8;
  localparam int SLOT_W          = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int TOT_W           = $clog2(CHUNKS + 1);

  // field widths
  localparam int SEQ_W  = 16;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;

  // result kinds
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture the input transfer
    logic update;    // write store, set marks, take total
    logic check;     // fold completion into the sticky flag
    logic ld_ack;    // load an acknowledgement into the output register
    logic ld_empty;  // load the empty-message result
    logic rd;        // read store entry at the emit index
    logic ld_data;   // load the read entry into the output register
    logic next;      // advance the emit index
    logic clear;     // drop marks, total, flag and emit index after emission
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic in_range;
    logic skip;
    logic complete;
    logic total_zero;
    logic out_last;
  } dp_sts_t;

  // byte-lane mask for the first len bytes
  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      if (b < int'(len)) m[b*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/core/chunk_reassembly_receiver.sv]
// ----------------------------------------------------------------------------
// chunk_reassembly_receiver
// Selective-repeat receiver that acknowledges chunks and reassembles messages.
// ----------------------------------------------------------------------------
// Takes one chunk per input transfer and handles it alone. A chunk with a
// sequence number beyond the store frees the input from the update state;
// otherwise the store update and completion check follow, and the
// acknowledgement (unless skipped) is offered on the next cycle. When the
// message completes, every stored chunk is emitted in order, one result at
// a time (read, load, offer), set by the single registered read port of
// the chunk store; the next read waits for the result to be taken, and
// input is held off until the last chunk is taken. An empty message gives
// one zero-length result. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_reassembly_receiver
  import crr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [SEQ_W-1:0]  in_chunk_seq,
  input  wire logic [SEQ_W-1:0]  in_chunk_total,
  input  wire logic [LEN_W-1:0]  in_chunk_len,
  input  wire logic [DATA_W-1:0] in_chunk_bytes,
  input  wire logic              in_skip_ack,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_result_kind,
  output logic [SEQ_W-1:0]       out_ack_seq,
  output logic [DATA_W-1:0]      out_out_bytes,
  output logic [LEN_W-1:0]       out_out_len,
  output logic                   out_last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing
  crr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // storage and result formation
  crr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_chunk_seq    (in_chunk_seq),
    .in_chunk_total  (in_chunk_total),
    .in_chunk_len    (in_chunk_len),
    .in_chunk_bytes  (in_chunk_bytes),
    .in_skip_ack     (in_skip_ack),
    .out_result_kind (out_result_kind),
    .out_ack_seq     (out_ack_seq),
    .out_out_bytes   (out_out_bytes),
    .out_out_len     (out_out_len),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

[rtl/core/crr_ram.sv]
// ----------------------------------------------------------------------------
// crr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module crr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/crr_dp.sv]
// ----------------------------------------------------------------------------
// crr_dp
// Receiver datapath: input capture, chunk store, marks, completion check,
// emit index and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module crr_dp
  import crr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           cmd,
  output dp_sts_t                sts,
  input  wire logic [SEQ_W-1:0]  in_chunk_seq,
  input  wire logic [SEQ_W-1:0]  in_chunk_total,
  input  wire logic [LEN_W-1:0]  in_chunk_len,
  input  wire logic [DATA_W-1:0] in_chunk_bytes,
  input  wire logic              in_skip_ack,
  output logic                   out_result_kind,
  output logic [SEQ_W-1:0]       out_ack_seq,
  output logic [DATA_W-1:0]      out_out_bytes,
  output logic [LEN_W-1:0]       out_out_len,
  output logic                   out_last
);

  // captured input
  logic [SEQ_W-1:0]  seq_r;
  logic [TOT_W-1:0]  tot_in_r;
  logic [LEN_W-1:0]  len_r;
  logic [DATA_W-1:0] bytes_r;
  logic              skip_r;

  // message state
  logic [CHUNKS-1:0] recv_r;
  logic [CHUNKS-1:0] ackd_r;
  logic [TOT_W-1:0]  total_r;
  logic              flag_r;
  logic [TOT_W-1:0]  idx_r;

  logic [LEN_W-1:0]        len_c;
  logic [TOT_W-1:0]        tot_c;
  logic [SLOT_W-1:0]       slot;
  logic [CHUNKS-1:0]       live;
  logic                    all_recv;
  logic                    all_ackd;
  logic [TOT_W:0]          idx_inc;
  logic [DATA_W+LEN_W-1:0] rd_data;

  // clamp length and total on the way in
  assign len_c = (in_chunk_len > LEN_W'(BYTES_PER_CHUNK)) ? LEN_W'(BYTES_PER_CHUNK)
                                                          : in_chunk_len;
  assign tot_c = (in_chunk_total > SEQ_W'(CHUNKS)) ? TOT_W'(CHUNKS)
                                                   : in_chunk_total[TOT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seq_r    <= in_chunk_seq;
      tot_in_r <= tot_c;
      len_r    <= len_c;
      bytes_r  <= in_chunk_bytes & byte_mask(len_c);
      skip_r   <= in_skip_ack;
    end
  end

  assign slot = seq_r[SLOT_W-1:0];

  // slots below the current total
  for (genvar i = 0; i < CHUNKS; i++) begin : g_live
    assign live[i] = (TOT_W'(i) < total_r);
  end

  assign all_recv = flag_r | (&(recv_r | ~live));
  assign all_ackd = &(ackd_r | ~live);
  assign idx_inc  = {1'b0, idx_r} + (TOT_W+1)'(1);

  // marks, total, sticky flag, emit index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recv_r  <= '0;
      ackd_r  <= '0;
      total_r <= '0;
      flag_r  <= 1'b0;
      idx_r   <= '0;
    end else if (cmd.clear) begin
      recv_r  <= '0;
      ackd_r  <= '0;
      total_r <= '0;
      flag_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (cmd.update) begin
        recv_r[slot] <= 1'b1;
        if (!skip_r) ackd_r[slot] <= 1'b1;
        total_r <= tot_in_r;
      end
      if (cmd.check) flag_r <= all_recv;
      if (cmd.next)  idx_r  <= idx_inc[TOT_W-1:0];
    end
  end

  // chunk store: bytes in the low part, length on top
  crr_ram #(
    .WIDTH (DATA_W + LEN_W),
    .DEPTH (CHUNKS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (slot),
    .wdata ({len_r, bytes_r}),
    .re    (cmd.rd),
    .raddr (idx_r[SLOT_W-1:0]),
    .rdata (rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.ld_ack) begin
      out_result_kind <= KIND_ACK;
      out_ack_seq     <= seq_r;
      out_out_bytes   <= '0;
      out_out_len     <= '0;
      out_last        <= ~(all_recv & all_ackd);
    end else if (cmd.ld_empty) begin
      out_result_kind <= KIND_DATA;
      out_ack_seq     <= '0;
      out_out_bytes   <= '0;
      out_out_len     <= '0;
      out_last        <= 1'b1;
    end else if (cmd.ld_data) begin
      out_result_kind <= KIND_DATA;
      out_ack_seq     <= SEQ_W'(idx_r);
      out_out_bytes   <= rd_data[DATA_W-1:0];
      out_out_len     <= rd_data[DATA_W +: LEN_W];
      out_last        <= (idx_inc == {1'b0, total_r});
    end
  end

  // status back to the controller
  always_comb begin
    sts.in_range   = (seq_r < SEQ_W'(CHUNKS));
    sts.skip       = skip_r;
    sts.complete   = all_recv & all_ackd;
    sts.total_zero = (total_r == '0);
    sts.out_last   = out_last;
  end

endmodule

`default_nettype wire

[rtl/core/crr_ctrl.sv]
// ----------------------------------------------------------------------------
// crr_ctrl
// Receiver controller: sequences capture, store update, completion check,
// acknowledgement and in-order emission.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chunk_reassembly_receiver_macros.svh"

module crr_ctrl
  import crr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_CHK,
    S_ACK,
    S_START,
    S_RD,
    S_LD,
    S_DATA
  } state_t;

  state_t state_r, state_nxt;
  logic   done_r, done_nxt;   // completion pending behind an acknowledgement

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_ACK) || (state_r == S_DATA);

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (sts.in_range) begin
          cmd.update = 1'b1;
          state_nxt  = S_CHK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CHK: begin
        cmd.check = 1'b1;
        if (!sts.skip) begin
          cmd.ld_ack = 1'b1;
          done_nxt   = sts.complete;
          state_nxt  = S_ACK;
        end else if (sts.complete) begin
          state_nxt = S_START;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ACK: begin
        if (out_ready) state_nxt = done_r ? S_START : S_IDLE;
      end
      S_START: begin
        if (sts.total_zero) begin
          cmd.ld_empty = 1'b1;
          state_nxt    = S_DATA;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LD;
      end
      S_LD: begin
        cmd.ld_data = 1'b1;
        state_nxt   = S_DATA;
      end
      S_DATA: begin
        if (out_ready) begin
          if (sts.out_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.next  = 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // input is never taken while a result is on offer
  `CRR_ASSERT_NOW(a_no_overlap, clk, rst_n, in_ready, !out_valid)
  // an accepted chunk always moves on to the store update
  `CRR_ASSERT_NEXT(a_load_to_upd, clk, rst_n, in_valid && in_ready, state_r == S_UPD)
  // last emitted chunk clears the message and returns to idle
  `CRR_ASSERT_NEXT(a_last_to_idle, clk, rst_n,
                   state_r == S_DATA && out_ready && sts.out_last,
                   state_r == S_IDLE && sts.total_zero)

endmodule

`default_nettype wire
